### rtl/vn2d_pkg.sv
// shared types, constants and helpers for the 2d value noise pipeline
`default_nettype none

package vn2d_pkg;

  // hash table geometry, table size must be a power of two
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // coordinate format: signed q(32-frac).frac
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 16;

  // stream widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 16;

  // pipeline depth, stage 1 is the input register, the last one the output register
  localparam int NUM_STAGES  = 8;
  localparam int FADE_STAGES = 5;

  // fade polynomial 6t^5 - 15t^4 + 10t^3
  localparam int FADE_C5 = 6;
  localparam int FADE_C4 = 15;
  localparam int FADE_C3 = 10;
  localparam int FADE_SUM_W = 21;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  typedef struct packed {
    logic en1;    // stage 1 loads
    logic en2;    // stage 2 loads
    logic we_a;   // load item accepted, write first-level copy
    logic we_bc;  // load item leaves stage 1, write corner copies
  } hash_ctl_t;

  // floored integer cell, wrapped to the table
  function automatic logic [IDX_W-1:0] cell_of(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] sh;
    sh = $signed(raw) >>> FRAC_BITS;
    return sh[IDX_W-1:0];
  endfunction

  // coordinate fraction as q0.16, truncated
  function automatic logic [Q_W-1:0] frac_of(input logic [COORD_W-1:0] raw);
    logic [FRAC_BITS+Q_W-1:0] ext;
    ext = {raw[FRAC_BITS-1:0], {Q_W{1'b0}}};
    return ext[FRAC_BITS +: Q_W];
  endfunction

  // hash byte scaled by 257 to a q0.16 fraction
  function automatic logic [Q_W-1:0] corner16(input logic [7:0] h);
    return {h, h};
  endfunction

endpackage

`default_nettype wire

### rtl/value_noise_2d.sv
// top level of the 2d value noise pipeline with quintic fade
`default_nettype none

// 2d value noise, one item per clock unless the output stalls. an evaluate item carries a signed
// q16.16 point; its cell (floored, wrapped to 256) picks four lattice corners
// hashed as T[(cx + T[cy]) mod 256], each byte scaled by 257 to q0.16. both
// fractions go through the fade 6t^5 - 15t^4 + 10t^3 and a bilinear lerp
// gives the 16-bit result. a load item writes one table byte and gives no
// result; evaluate items must only touch entries already loaded, there is no
// clearing after reset. throughput is one item per cycle in both directions
// while the output is not stalled, through eight register stages, the input
// register included. the rate is held by three copies of the hash table
// (two reads each per cycle) and by a 5-stage fade multiplier chain; a
// stalled output stops only the stages that are full, so bubbles still
// drain and the input keeps accepting until the pipe fills.
// loads write each table copy at the stage where evaluates read it, so items
// see the table in exactly their arrival order.

module value_noise_2d import vn2d_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i, // table_index, table_value, x_coord, y_coord
  input  wire logic                 s_axis_tuser_i, // func
  // result items
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o  // noise_value
);

  // input fields
  func_e               in_func;
  logic [7:0]          in_idx;
  logic [7:0]          in_val;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;

  assign in_func = func_e'(s_axis_tuser_i);
  assign in_idx  = s_axis_tdata_i[7:0];
  assign in_val  = s_axis_tdata_i[15:8];
  assign in_x    = s_axis_tdata_i[47:16];
  assign in_y    = s_axis_tdata_i[79:48];

  // stage valids and per-stage load enables
  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:1] v_in;
  logic [NUM_STAGES:1] adv;

  func_e func_q1, func_q2;

  // stage 1 fractions feed the fade units
  logic [Q_W-1:0] fx_q1, fy_q1;

  hash_ctl_t  hash_ctl;
  logic [7:0] h00, h10, h01, h11;

  // corners carried from stage 3 to stage 6
  logic [4*Q_W-1:0] corner_q [3:6];
  logic [4*Q_W-1:0] corner2;

  logic [Q_W-1:0] fade_x, fade_y;
  logic [Q_W-1:0] fade_y_q7;
  logic [Q_W-1:0] top, bot;
  logic [Q_W-1:0] noise;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NUM_STAGES] = !v_q[NUM_STAGES] || m_axis_tready_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  // loads are finished after stage 2 and leave the pipe there
  always_comb begin
    v_in[1] = s_axis_tvalid_i;
    for (int k = 2; k <= NUM_STAGES; k++) begin
      v_in[k] = v_q[k-1];
    end
    v_in[3] = v_q[2] && (func_q2 == FUNC_EVAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      func_q1 <= in_func;
      fx_q1   <= frac_of(in_x);
      fy_q1   <= frac_of(in_y);
    end
    if (adv[2]) begin
      func_q2 <= func_q1;
    end
  end

  assign s_axis_tready_o = adv[1];

  // table lookup
  assign hash_ctl.en1   = adv[1];
  assign hash_ctl.en2   = adv[2];
  assign hash_ctl.we_a  = s_axis_tvalid_i && adv[1] && (in_func == FUNC_LOAD);
  assign hash_ctl.we_bc = v_q[1] && adv[2] && (func_q1 == FUNC_LOAD);

  vn2d_hash u_hash (
    .clk_i (clk_i),
    .ctl_i (hash_ctl),
    .idx_i (in_idx),
    .val_i (in_val),
    .cx_i  (cell_of(in_x)),
    .cy_i  (cell_of(in_y)),
    .h00_o (h00),
    .h10_o (h10),
    .h01_o (h01),
    .h11_o (h11)
  );

  // fade, stages 2 to 6
  vn2d_fade u_fade_x (
    .clk_i  (clk_i),
    .en_i   (adv[6:2]),
    .t_i    (fx_q1),
    .fade_o (fade_x)
  );

  vn2d_fade u_fade_y (
    .clk_i  (clk_i),
    .en_i   (adv[6:2]),
    .t_i    (fy_q1),
    .fade_o (fade_y)
  );

  // corner delay line, packed as 11, 01, 10, 00 from the top
  assign corner2 = {corner16(h11), corner16(h01), corner16(h10), corner16(h00)};

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      corner_q[3] <= corner2;
    end
    for (int k = 4; k <= 6; k++) begin
      if (adv[k]) begin
        corner_q[k] <= corner_q[k-1];
      end
    end
    if (adv[7]) begin
      fade_y_q7 <= fade_y;
    end
  end

  // x interpolation at stage 7, y interpolation into the output register
  vn2d_lerp u_lerp_top (
    .clk_i (clk_i),
    .en_i  (adv[7]),
    .a_i   (corner_q[6][Q_W-1:0]),
    .b_i   (corner_q[6][2*Q_W-1:Q_W]),
    .f_i   (fade_x),
    .r_o   (top)
  );

  vn2d_lerp u_lerp_bot (
    .clk_i (clk_i),
    .en_i  (adv[7]),
    .a_i   (corner_q[6][3*Q_W-1:2*Q_W]),
    .b_i   (corner_q[6][4*Q_W-1:3*Q_W]),
    .f_i   (fade_x),
    .r_o   (bot)
  );

  vn2d_lerp u_lerp_y (
    .clk_i (clk_i),
    .en_i  (adv[8]),
    .a_i   (top),
    .b_i   (bot),
    .f_i   (fade_y_q7),
    .r_o   (noise)
  );

  assign m_axis_tvalid_o = v_q[NUM_STAGES];
  assign m_axis_tdata_o  = noise;

`ifndef SYNTHESIS
  // input only backs up once every stage holds an item
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipe");

  // a held stage 7 item keeps its interpolated values
  a_stage7_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[7] && !adv[8]) |=> (v_q[7] && $stable(top) && $stable(bot)))
    else $error("stage 7 item lost while stalled");

  // a new result comes only from an item that sat in stage 7
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v_q[NUM_STAGES-1]))
    else $error("result appeared without a stage 7 item");
`endif

endmodule

`default_nettype wire

### rtl/vn2d_hash.sv
// hash table copies and the two-level corner lookup (stages 1 and 2)
`default_nettype none

module vn2d_hash import vn2d_pkg::*; (
  input  wire logic             clk_i,
  input  wire hash_ctl_t        ctl_i,
  input  wire logic [7:0]       idx_i,
  input  wire logic [7:0]       val_i,
  input  wire logic [IDX_W-1:0] cx_i,
  input  wire logic [IDX_W-1:0] cy_i,
  output logic [7:0]            h00_o,
  output logic [7:0]            h10_o,
  output logic [7:0]            h01_o,
  output logic [7:0]            h11_o
);

  // three copies so one item needs at most two reads per copy per cycle
  logic [7:0] mem_a [TABLE_SIZE];
  logic [7:0] mem_b [TABLE_SIZE];
  logic [7:0] mem_c [TABLE_SIZE];

  logic [IDX_W+7:0] idx_ext;
  logic             idx_ok;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] cy1;

  logic [IDX_W-1:0] cx_q;
  logic [IDX_W-1:0] waddr_q;
  logic             idx_ok_q;
  logic [7:0]       val_q;
  logic [7:0]       ty0_q;
  logic [7:0]       ty1_q;

  logic [IDX_W-1:0] cx1;
  logic [IDX_W-1:0] a00, a10, a01, a11;

  function automatic logic [IDX_W-1:0] add_wrap(input logic [IDX_W-1:0] c,
                                                input logic [7:0] t);
    logic [IDX_W+7:0] s;
    s = (IDX_W+8)'(c) + (IDX_W+8)'(t);
    return s[IDX_W-1:0];
  endfunction

  assign idx_ext = (IDX_W+8)'(idx_i);
  assign idx_ok  = idx_ext < (IDX_W+8)'(TABLE_SIZE);
  assign waddr   = idx_ext[IDX_W-1:0];
  assign cy1     = cy_i + IDX_W'(1);

  assign cx1 = cx_q + IDX_W'(1);
  assign a00 = add_wrap(cx_q, ty0_q);
  assign a10 = add_wrap(cx1,  ty0_q);
  assign a01 = add_wrap(cx_q, ty1_q);
  assign a11 = add_wrap(cx1,  ty1_q);

  // first level: row hashes, read as the item enters
  always_ff @(posedge clk_i) begin
    if (ctl_i.we_a && idx_ok) begin
      mem_a[waddr] <= val_i;
    end
    if (ctl_i.en1) begin
      ty0_q    <= mem_a[cy_i];
      ty1_q    <= mem_a[cy1];
      cx_q     <= cx_i;
      waddr_q  <= waddr;
      idx_ok_q <= idx_ok;
      val_q    <= val_i;
    end
  end

  // second level: corner hashes
  always_ff @(posedge clk_i) begin
    if (ctl_i.we_bc && idx_ok_q) begin
      mem_b[waddr_q] <= val_q;
    end
    if (ctl_i.en2) begin
      h00_o <= mem_b[a00];
      h10_o <= mem_b[a10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_bc && idx_ok_q) begin
      mem_c[waddr_q] <= val_q;
    end
    if (ctl_i.en2) begin
      h01_o <= mem_c[a01];
      h11_o <= mem_c[a11];
    end
  end

endmodule

`default_nettype wire

### rtl/vn2d_fade.sv
// pipelined quintic fade 6t^5 - 15t^4 + 10t^3 on a q0.16 fraction
`default_nettype none

module vn2d_fade import vn2d_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic [FADE_STAGES-1:0] en_i,
  input  wire logic [Q_W-1:0]         t_i,
  output logic [Q_W-1:0]              fade_o
);

  logic [2*Q_W-1:0] p2, p3, p4, p5;

  logic [Q_W-1:0] t2_q, ta_q;
  logic [Q_W-1:0] t3_q, tb_q;
  logic [Q_W-1:0] t4_q, tc_q, t3b_q;
  logic [Q_W-1:0] t5_q, t4b_q, t3c_q;

  logic [FADE_SUM_W-1:0] pos, neg, diff;

  assign p2 = (2*Q_W)'(t_i)  * (2*Q_W)'(t_i);
  assign p3 = (2*Q_W)'(t2_q) * (2*Q_W)'(ta_q);
  assign p4 = (2*Q_W)'(t3_q) * (2*Q_W)'(tb_q);
  assign p5 = (2*Q_W)'(t4_q) * (2*Q_W)'(tc_q);

  assign pos  = FADE_SUM_W'(FADE_C5) * FADE_SUM_W'(t5_q)
              + FADE_SUM_W'(FADE_C3) * FADE_SUM_W'(t3c_q);
  assign neg  = FADE_SUM_W'(FADE_C4) * FADE_SUM_W'(t4b_q);
  assign diff = pos - neg;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t2_q <= p2[2*Q_W-1:Q_W];
      ta_q <= t_i;
    end
    if (en_i[1]) begin
      t3_q <= p3[2*Q_W-1:Q_W];
      tb_q <= ta_q;
    end
    if (en_i[2]) begin
      t4_q  <= p4[2*Q_W-1:Q_W];
      tc_q  <= tb_q;
      t3b_q <= t3_q;
    end
    if (en_i[3]) begin
      t5_q  <= p5[2*Q_W-1:Q_W];
      t4b_q <= t4_q;
      t3c_q <= t3b_q;
    end
    // saturate to [0, 1.0)
    if (en_i[4]) begin
      if (pos <= neg) begin
        fade_o <= '0;
      end else if (diff > FADE_SUM_W'({Q_W{1'b1}})) begin
        fade_o <= '1;
      end else begin
        fade_o <= diff[Q_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vn2d_lerp.sv
// one registered linear interpolation a + trunc((b - a) * f), q0.16
`default_nettype none

module vn2d_lerp import vn2d_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [Q_W-1:0] a_i,
  input  wire logic [Q_W-1:0] b_i,
  input  wire logic [Q_W-1:0] f_i,
  output logic [Q_W-1:0]      r_o
);

  logic             up;
  logic [Q_W-1:0]   mag;
  logic [2*Q_W-1:0] prod;
  logic [Q_W-1:0]   m;

  // work on the magnitude so the step truncates toward zero
  assign up   = b_i >= a_i;
  assign mag  = up ? (b_i - a_i) : (a_i - b_i);
  assign prod = (2*Q_W)'(mag) * (2*Q_W)'(f_i);
  assign m    = prod[2*Q_W-1:Q_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o <= up ? (a_i + m) : (a_i - m);
    end
  end

endmodule

`default_nettype wire
